[rtl/rpn_pkg.sv]
// rpn_pkg: shared types, constants and state codes of the rpn stack calculator
// used by every module under rtl except rpn_ram; depends on nothing
package rpn_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_WIDTH  = 32;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CH_W        = 8;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 3;

  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_TIMES = 8'h2A;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_FEW_ARGS = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_DIV_ZERO = 3'd4
  } rpn_status_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
  } rpn_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [STATUS_W-1:0]       status;
  } rpn_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PUSH_MID,
    S_DISPATCH,
    S_EXEC,
    S_DIV,
    S_LAST,
    S_PUSH_END,
    S_FIN
  } rpn_state_t;

  typedef struct packed {
    logic        load_byte;
    logic        acc_digit;
    logic        end_num;
    logic        push;
    logic        fail;
    rpn_status_t fail_code;
    logic        set_halt;
    logic        rd_b;
    logic        exec_op;
    logic        div_start;
    logic        div_pop;
    logic        emit;
    logic        clear;
  } rpn_cmd_t;

  typedef struct packed {
    logic halted;
    logic is_digit;
    logic in_number;
    logic is_nul;
    logic is_op;
    logic is_div;
    logic last;
    logic full;
    logic few;
    logic a_zero;
    logic div_done;
    logic out_free;
  } rpn_stat_t;

endpackage

[rtl/rpn_ram.sv]
// rpn_ram: generic single-write, single-read memory with registered read data
// no dependencies
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/rpn_div.sv]
// rpn_div: iterative signed divider, one quotient bit per cycle, truncating
// depends on rpn_pkg
module rpn_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [rpn_pkg::DATA_WIDTH-1:0] dividend,
  input  logic [rpn_pkg::DATA_WIDTH-1:0] divisor,
  input  logic                           neg,
  output logic                           busy,
  output logic                           done,
  output logic [rpn_pkg::DATA_WIDTH-1:0] quotient
);

  localparam int W     = rpn_pkg::DATA_WIDTH;
  localparam int CNT_W = $clog2(W);

  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             neg_r, neg_nxt;
  logic [W:0]       rem_sh;
  logic [W:0]       diff;
  logic             ge;

  always_comb begin
    rem_sh   = {rem_r, quo_r[W-1]};
    diff     = rem_sh - {1'b0, dvs_r};
    ge       = !diff[W];
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      neg_nxt  = neg;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[W-1:0] : rem_sh[W-1:0];
      quo_nxt = {quo_r[W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = neg_r ? (W'(0) - quo_r) : quo_r;

endmodule

[rtl/rpn_dp.sv]
// rpn_dp: datapath of the rpn calculator: byte latch, number builder, stack
// with top in a register, alu, divider and output register; uses rpn_pkg,
// rpn_ram and rpn_div
module rpn_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  rpn_pkg::rpn_in_t  in_data,
  input  rpn_pkg::rpn_cmd_t cmd,
  output rpn_pkg::rpn_stat_t stat,
  output logic              out_valid,
  input  logic              out_ready,
  output rpn_pkg::rpn_out_t out_data
);

  localparam int W = rpn_pkg::DATA_WIDTH;

  logic [rpn_pkg::CH_W-1:0]    ch_r, ch_nxt;
  logic                        last_r, last_nxt;
  logic [W-1:0]                acc_r, acc_nxt;
  logic                        in_num_r, in_num_nxt;
  logic [W-1:0]                tos_r, tos_nxt;
  logic [rpn_pkg::DEPTH_W-1:0] depth_r, depth_nxt;
  rpn_pkg::rpn_status_t        err_r, err_nxt;
  logic                        halted_r, halted_nxt;
  logic                        out_valid_r, out_valid_nxt;
  rpn_pkg::rpn_out_t           out_data_r, out_data_nxt;

  logic [W-1:0]                b_word;
  logic [W-1:0]                alu_res;
  logic [W-1:0]                mag_a, mag_b;
  logic [W-1:0]                quotient;
  logic                        div_busy, div_done;
  logic                        ram_we;
  logic [rpn_pkg::ADDR_W-1:0]  waddr, raddr;

  assign waddr  = rpn_pkg::ADDR_W'(depth_r - rpn_pkg::DEPTH_W'(1));
  assign raddr  = rpn_pkg::ADDR_W'(depth_r - rpn_pkg::DEPTH_W'(2));
  assign ram_we = cmd.push && (depth_r != '0);

  rpn_ram #(
    .WIDTH(W),
    .DEPTH(rpn_pkg::STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(tos_r),
    .re   (cmd.rd_b),
    .raddr(raddr),
    .rdata(b_word)
  );

  assign mag_a = tos_r[W-1]  ? (W'(0) - tos_r)  : tos_r;
  assign mag_b = b_word[W-1] ? (W'(0) - b_word) : b_word;

  rpn_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend(mag_b),
    .divisor (mag_a),
    .neg     (tos_r[W-1] ^ b_word[W-1]),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(quotient)
  );

  always_comb begin
    priority if (ch_r == rpn_pkg::CH_PLUS) begin
      alu_res = b_word + tos_r;
    end else if (ch_r == rpn_pkg::CH_MINUS) begin
      alu_res = b_word - tos_r;
    end else begin
      alu_res = W'(b_word * tos_r);
    end
  end

  always_comb begin
    stat.halted    = halted_r;
    stat.is_digit  = (ch_r >= rpn_pkg::CH_ZERO) && (ch_r <= rpn_pkg::CH_NINE);
    stat.in_number = in_num_r;
    stat.is_nul    = (ch_r == rpn_pkg::CH_NUL);
    stat.is_op     = (ch_r == rpn_pkg::CH_PLUS) || (ch_r == rpn_pkg::CH_MINUS) ||
                     (ch_r == rpn_pkg::CH_TIMES) || (ch_r == rpn_pkg::CH_SLASH);
    stat.is_div    = (ch_r == rpn_pkg::CH_SLASH);
    stat.last      = last_r;
    stat.full      = (depth_r >= rpn_pkg::DEPTH_W'(rpn_pkg::STACK_DEPTH));
    stat.few       = (depth_r < rpn_pkg::DEPTH_W'(2));
    stat.a_zero    = (tos_r == '0);
    stat.div_done  = div_done;
    stat.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    ch_nxt        = ch_r;
    last_nxt      = last_r;
    acc_nxt       = acc_r;
    in_num_nxt    = in_num_r;
    tos_nxt       = tos_r;
    depth_nxt     = depth_r;
    err_nxt       = err_r;
    halted_nxt    = halted_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (cmd.load_byte) begin
      ch_nxt   = in_data.ch;
      last_nxt = in_data.last;
    end
    if (cmd.acc_digit) begin
      acc_nxt    = {acc_r[W-4:0], 3'b000} + {acc_r[W-2:0], 1'b0} + W'(ch_r[3:0]);
      in_num_nxt = 1'b1;
    end
    if (cmd.end_num) begin
      acc_nxt    = '0;
      in_num_nxt = 1'b0;
    end
    if (cmd.push) begin
      tos_nxt   = acc_r;
      depth_nxt = depth_r + rpn_pkg::DEPTH_W'(1);
    end
    if (cmd.fail) begin
      err_nxt    = cmd.fail_code;
      halted_nxt = 1'b1;
    end
    if (cmd.set_halt) begin
      halted_nxt = 1'b1;
    end
    if (cmd.exec_op) begin
      tos_nxt   = alu_res;
      depth_nxt = depth_r - rpn_pkg::DEPTH_W'(1);
    end
    if (cmd.div_pop) begin
      tos_nxt   = quotient;
      depth_nxt = depth_r - rpn_pkg::DEPTH_W'(1);
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      if (err_r != rpn_pkg::ST_OK) begin
        out_data_nxt.value  = '0;
        out_data_nxt.status = err_r;
      end else if (depth_r == '0) begin
        out_data_nxt.value  = '0;
        out_data_nxt.status = rpn_pkg::ST_EMPTY;
      end else begin
        out_data_nxt.value  = rpn_pkg::VALUE_W'($signed(tos_r));
        out_data_nxt.status = rpn_pkg::ST_OK;
      end
    end
    if (cmd.clear) begin
      acc_nxt    = '0;
      in_num_nxt = 1'b0;
      depth_nxt  = '0;
      err_nxt    = rpn_pkg::ST_OK;
      halted_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      in_num_r    <= 1'b0;
      depth_r     <= '0;
      err_r       <= rpn_pkg::ST_OK;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      in_num_r    <= in_num_nxt;
      depth_r     <= depth_nxt;
      err_r       <= err_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ch_r       <= ch_nxt;
    last_r     <= last_nxt;
    tos_r      <= tos_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= rpn_pkg::DEPTH_W'(rpn_pkg::STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (depth_r < rpn_pkg::DEPTH_W'(rpn_pkg::STACK_DEPTH)))
    else $error("push onto a full stack");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> (tos_r != '0) && !div_busy)
    else $error("divider started with zero divisor or while busy");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (depth_r == '0) && !halted_r && (err_r == rpn_pkg::ST_OK))
    else $error("state not cleared after result");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("result beat lost");

endmodule

[rtl/rpn_ctrl.sv]
// rpn_ctrl: sequencing state machine of the rpn calculator, one byte at a time
// depends on rpn_pkg; drives the datapath through rpn_cmd_t
module rpn_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rpn_pkg::rpn_stat_t  stat,
  output rpn_pkg::rpn_cmd_t   cmd
);

  rpn_pkg::rpn_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpn_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.fail_code = rpn_pkg::ST_OK;
    unique case (state_r)
      rpn_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_byte = 1'b1;
          state_nxt     = rpn_pkg::S_DECODE;
        end
      end
      rpn_pkg::S_DECODE: begin
        priority if (stat.halted) begin
          state_nxt = rpn_pkg::S_LAST;
        end else if (stat.is_digit) begin
          cmd.acc_digit = 1'b1;
          state_nxt     = rpn_pkg::S_LAST;
        end else if (stat.in_number) begin
          state_nxt = rpn_pkg::S_PUSH_MID;
        end else begin
          state_nxt = rpn_pkg::S_DISPATCH;
        end
      end
      rpn_pkg::S_PUSH_MID: begin
        cmd.end_num = 1'b1;
        if (stat.full) begin
          cmd.fail      = 1'b1;
          cmd.fail_code = rpn_pkg::ST_OVERFLOW;
        end else begin
          cmd.push = 1'b1;
        end
        state_nxt = rpn_pkg::S_DISPATCH;
      end
      rpn_pkg::S_DISPATCH: begin
        state_nxt = rpn_pkg::S_LAST;
        priority if (stat.halted) begin
          state_nxt = rpn_pkg::S_LAST;
        end else if (stat.is_nul) begin
          cmd.set_halt = 1'b1;
        end else if (stat.is_op) begin
          if (stat.few) begin
            cmd.fail      = 1'b1;
            cmd.fail_code = rpn_pkg::ST_FEW_ARGS;
          end else begin
            cmd.rd_b  = 1'b1;
            state_nxt = rpn_pkg::S_EXEC;
          end
        end else begin
          state_nxt = rpn_pkg::S_LAST;
        end
      end
      rpn_pkg::S_EXEC: begin
        state_nxt = rpn_pkg::S_LAST;
        if (stat.is_div) begin
          if (stat.a_zero) begin
            cmd.fail      = 1'b1;
            cmd.fail_code = rpn_pkg::ST_DIV_ZERO;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = rpn_pkg::S_DIV;
          end
        end else begin
          cmd.exec_op = 1'b1;
        end
      end
      rpn_pkg::S_DIV: begin
        if (stat.div_done) begin
          cmd.div_pop = 1'b1;
          state_nxt   = rpn_pkg::S_LAST;
        end
      end
      rpn_pkg::S_LAST: begin
        priority if (!stat.last) begin
          state_nxt = rpn_pkg::S_IDLE;
        end else if (!stat.halted && stat.in_number) begin
          state_nxt = rpn_pkg::S_PUSH_END;
        end else begin
          state_nxt = rpn_pkg::S_FIN;
        end
      end
      rpn_pkg::S_PUSH_END: begin
        cmd.end_num = 1'b1;
        if (stat.full) begin
          cmd.fail      = 1'b1;
          cmd.fail_code = rpn_pkg::ST_OVERFLOW;
        end else begin
          cmd.push = 1'b1;
        end
        state_nxt = rpn_pkg::S_FIN;
      end
      rpn_pkg::S_FIN: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.clear = 1'b1;
          state_nxt = rpn_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rpn_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/rpn_stack_calculator.sv]
// rpn_stack_calculator: top level of the reverse-polish integer calculator
// depends on rpn_pkg, rpn_ctrl and rpn_dp (with rpn_ram and rpn_div)
//
// in channel: one text byte per beat (in_data.ch) with in_data.last marking
// the final byte of an expression. digits build a 32-bit number, other bytes
// end it; + - * / combine the top two stack entries, byte zero stops
// evaluation, anything else is skipped. the stack holds 64 words: the top in
// a register, the rest in a single-port-write ram with registered read.
// out channel: one beat per expression, sent after the last byte, carrying
// the top of stack and a status code (ok, overflow, too few operands, empty
// stack, divide by zero); value is 0 unless status is ok.
// sequencing: one byte at a time; a digit goes through idle, decode and last,
// any other byte through dispatch too (after push_mid when it ends a number);
// + - * add exec, and / adds exec and div, where the shift-subtract divider
// sets the pace; a last byte adds fin to load the result, after push_end when
// a pending number is pushed first; out_valid rises the cycle after the load.
// the result sits in an output register, so the next expression's bytes are
// taken while it waits; a further result waits only if that register is full.
// reset (rst_n low, synchronous) empties the stack and clears any error; the
// same clearing happens whenever a result is loaded into the output register.
module rpn_stack_calculator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rpn_pkg::rpn_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rpn_pkg::rpn_out_t out_data
);

  rpn_pkg::rpn_cmd_t  cmd;
  rpn_pkg::rpn_stat_t stat;

  rpn_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  rpn_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
